/* src/rabs_pkg.sv */
// shared types and constants for the running-average background subtractor
// no dependencies; imported by the front, back and top-level modules
package rabs_pkg;

    // frame geometry and field widths
    localparam int PIXEL_COUNT = 524288;
    localparam int PIX_IDX_W   = 19;
    localparam int PIX_W       = 8;
    localparam int CHAN_COUNT  = 3;
    localparam int CNT_W       = 8;
    localparam int ALPHA_W     = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    // background memory: one word per pixel, counter above the three channels
    localparam int MEM_AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int WORD_W = CHAN_COUNT * PIX_W + CNT_W;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROCESS = 1'b1;

    // full-scale alpha in Q8
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PROCESS = 2'd1,
        OP_SKIP    = 2'd2
    } op_t;

    typedef struct packed {
        op_t                                op;
        logic [PIX_IDX_W-1:0]               idx;
        logic [CHAN_COUNT-1:0][PIX_W-1:0]   chan;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   diff_threshold;
        logic [ALPHA_W-1:0] blend_alpha_q8;
        logic               selective_update;
        logic [CNT_W-1:0]   absorb_limit;
        logic               color_mode;
    } cfg_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

/* src/running_average_background_subtractor_core.sv */
// running-average background subtractor: top level with configuration registers
// depends on rabs_pkg, rabs_front and rabs_back
//
// Per-pixel background subtraction at one pixel per clock while the output
// is not stalled. A load transfer (action 0) writes a pixel's background
// (all three channels) and clears its foreground counter; a process transfer
// (action 1) compares the pixel with its stored background, flags foreground
// when any used channel differs by more than diff_threshold, blends the
// background toward the pixel in Q8 (always, or only on background pixels
// when selective_update is set), and copies the pixel into the background
// once its saturating foreground counter exceeds absorb_limit. Every input
// transfer gives exactly one output transfer; an index outside the frame
// gives an all-zero result and touches nothing. The block sustains one
// transfer per clock while out_ready is high: the background memory has one
// read and one write port, each used once per pixel, and a pixel read right
// behind a write to the same pixel takes the forwarded word. A four-entry
// queue between the input classifier and the memory/compute back end lets
// each side stall on its own. The background memory is not cleared after
// reset: a pixel must be loaded before it is processed. Configuration
// writes are taken at once and must only be issued while no transfer is in
// flight.
module running_average_background_subtractor_core
    import rabs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [PIX_IDX_W-1:0]  pixel_index,
    input  logic [PIX_W-1:0]      chan0,
    input  logic [PIX_W-1:0]      chan1,
    input  logic [PIX_W-1:0]      chan2,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  foreground,
    output logic                  absorbed,
    output logic [PIX_W-1:0]      new_bg0,
    output logic [PIX_W-1:0]      new_bg1,
    output logic [PIX_W-1:0]      new_bg2
);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA_Q8   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECTIVE_UPDATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABSORB_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE       = 3'd4;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    head_t head;
    logic  head_pop;

    // register writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIFF_THRESHOLD:   cfg_next.diff_threshold   = cfg_wdata[PIX_W-1:0];
                REG_BLEND_ALPHA_Q8:   cfg_next.blend_alpha_q8   = cfg_wdata[ALPHA_W-1:0];
                REG_SELECTIVE_UPDATE: cfg_next.selective_update = cfg_wdata[0];
                REG_ABSORB_LIMIT:     cfg_next.absorb_limit     = cfg_wdata[CNT_W-1:0];
                REG_COLOR_MODE:       cfg_next.color_mode       = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold   <= PIX_W'(30);
            cfg_reg.blend_alpha_q8   <= ALPHA_W'(13);
            cfg_reg.selective_update <= 1'b1;
            cfg_reg.absorb_limit     <= CNT_W'(50);
            cfg_reg.color_mode       <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify and queue incoming pixels
    rabs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pixel_index (pixel_index),
        .chan0       (chan0),
        .chan1       (chan1),
        .chan2       (chan2),
        .head        (head),
        .pop         (head_pop)
    );

    // memory access, update and result register
    rabs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .pop        (head_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .foreground (foreground),
        .absorbed   (absorbed),
        .new_bg0    (new_bg0),
        .new_bg1    (new_bg1),
        .new_bg2    (new_bg2)
    );

`ifndef SYNTH
    // back end never pops an empty queue
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head.valid)
        else $error("queue popped while empty");

    // the queue holds an entry in the cycle after an accepted transfer
    a_push_reaches_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> head.valid)
        else $error("accepted transfer missing from queue");
`endif

endmodule

/* src/rabs_front.sv */
// front end: accepts pixel items, classifies them and queues them
// depends on rabs_pkg
module rabs_front
    import rabs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [PIX_IDX_W-1:0] pixel_index,
    input  logic [PIX_W-1:0]     chan0,
    input  logic [PIX_W-1:0]     chan1,
    input  logic [PIX_W-1:0]     chan2,
    output head_t                head,
    input  logic                 pop
);

    item_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                in_range;
    item_t               new_item;

    // classify: out-of-frame index gives an all-zero result and no store access
    always_comb
    begin
        in_range = 32'(pixel_index) < 32'(PIXEL_COUNT);
        new_item.idx = pixel_index;
        new_item.chan = {chan2, chan1, chan0};
        if (!in_range)
        begin
            new_item.op = OP_SKIP;
        end
        else if (action == ACT_LOAD)
        begin
            new_item.op = OP_LOAD;
        end
        else
        begin
            new_item.op = OP_PROCESS;
        end
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_mem[rd_ptr_reg];

endmodule

/* src/rabs_back.sv */
// back end: background/counter memory, per-pixel update and output register
// depends on rabs_pkg
module rabs_back
    import rabs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  head_t            head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             foreground,
    output logic             absorbed,
    output logic [PIX_W-1:0] new_bg0,
    output logic [PIX_W-1:0] new_bg1,
    output logic [PIX_W-1:0] new_bg2
);

    logic [WORD_W-1:0]  mem_array [PIXEL_COUNT];

    // compute stage
    logic               stage_valid_reg;
    item_t              stage_item_reg;
    logic [WORD_W-1:0]  rd_word_reg;
    logic               fwd_hit_reg;
    logic [WORD_W-1:0]  fwd_word_reg;

    // output register
    logic                             out_valid_reg;
    logic                             fg_reg;
    logic                             abs_reg;
    logic [CHAN_COUNT-1:0][PIX_W-1:0] bg_reg;

    logic                             out_free;
    logic                             stage_fire;
    logic                             stage_adv;
    logic                             mem_we;
    logic [MEM_AW-1:0]                wr_addr;
    logic [MEM_AW-1:0]                rd_addr;
    logic                             fwd_hit_next;

    logic [WORD_W-1:0]                cur_word;
    logic [WORD_W-1:0]                new_word;
    logic [CHAN_COUNT-1:0][PIX_W-1:0] bg_old;
    logic [CHAN_COUNT-1:0][PIX_W-1:0] bg_new;
    logic [CHAN_COUNT-1:0]            used;
    logic [CHAN_COUNT-1:0]            over;
    logic signed [PIX_W:0]            diff [CHAN_COUNT];
    logic [PIX_W-1:0]                 abs_diff [CHAN_COUNT];
    logic signed [18:0]               prod [CHAN_COUNT];
    logic signed [18:0]               blend_sum [CHAN_COUNT];
    logic signed [ALPHA_W:0]          alpha_s;
    logic [CNT_W-1:0]                 cnt_old;
    logic [CNT_W:0]                   cnt_sum;
    logic [CNT_W-1:0]                 cnt_sat;
    logic [CNT_W-1:0]                 cnt_new;
    logic                             fg;
    logic                             absorb;
    logic                             blend_on;
    logic                             res_fg;
    logic                             res_abs;
    logic [CHAN_COUNT-1:0][PIX_W-1:0] res_bg;

    assign out_free   = !out_valid_reg || out_ready;
    assign stage_fire = stage_valid_reg && out_free;
    assign stage_adv  = !stage_valid_reg || out_free;
    assign pop        = head.valid && stage_adv;

    assign mem_we  = stage_fire && (stage_item_reg.op != OP_SKIP);
    assign wr_addr = MEM_AW'(stage_item_reg.idx);
    assign rd_addr = MEM_AW'(head.item.idx);

    // memory reads before the write of the same edge, so that write is forwarded
    assign fwd_hit_next = mem_we && (wr_addr == rd_addr);

    always_comb
    begin
        cur_word = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
        cnt_old  = cur_word[WORD_W-1 -: CNT_W];
        alpha_s  = $signed({1'b0, cfg.blend_alpha_q8[ALPHA_W-1] ? ALPHA_ONE
                                                                  : cfg.blend_alpha_q8});
        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            bg_old[c]    = cur_word[c*PIX_W +: PIX_W];
            used[c]      = (c == 0) || cfg.color_mode;
            diff[c]      = $signed({1'b0, stage_item_reg.chan[c]}) - $signed({1'b0, bg_old[c]});
            abs_diff[c]  = diff[c][PIX_W] ? PIX_W'(-diff[c]) : PIX_W'(diff[c]);
            over[c]      = abs_diff[c] > cfg.diff_threshold;
            // b*256 + (p-b)*a + half, equals p*a + b*(256-a) + half
            prod[c]      = 19'(diff[c]) * 19'(alpha_s);
            blend_sum[c] = $signed({3'b000, bg_old[c], 8'h00}) + prod[c] + 19'sd128;
        end

        fg       = |(over & used);
        blend_on = !cfg.selective_update || !fg;
        cnt_sum  = {1'b0, cnt_old} + (CNT_W+1)'(fg);
        cnt_sat  = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
        absorb   = cnt_sat > cfg.absorb_limit;
        cnt_new  = fg ? cnt_sat : '0;

        for (int c = 0; c < CHAN_COUNT; c++)
        begin
            if (!used[c])
            begin
                bg_new[c] = bg_old[c];
            end
            else if (absorb)
            begin
                bg_new[c] = stage_item_reg.chan[c];
            end
            else if (blend_on)
            begin
                bg_new[c] = blend_sum[c][15:8];
            end
            else
            begin
                bg_new[c] = bg_old[c];
            end
        end

        case (stage_item_reg.op)
            OP_LOAD:
            begin
                new_word = {CNT_W'(0), stage_item_reg.chan};
                res_fg   = 1'b0;
                res_abs  = 1'b0;
                res_bg   = stage_item_reg.chan;
            end
            OP_PROCESS:
            begin
                new_word = {cnt_new, bg_new};
                res_fg   = fg;
                res_abs  = absorb;
                res_bg   = bg_new;
            end
            default:
            begin
                new_word = '0;
                res_fg   = 1'b0;
                res_abs  = 1'b0;
                res_bg   = '0;
            end
        endcase

        // gray mode reports only channel 0
        if (!cfg.color_mode)
        begin
            res_bg[1] = '0;
            res_bg[2] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[wr_addr] <= new_word;
        end
        if (pop)
        begin
            rd_word_reg <= mem_array[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (stage_adv)
            begin
                stage_valid_reg <= head.valid;
            end
            if (pop)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
            if (out_free)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stage_item_reg <= head.item;
            fwd_word_reg   <= new_word;
        end
        if (stage_fire)
        begin
            fg_reg  <= res_fg;
            abs_reg <= res_abs;
            bg_reg  <= res_bg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign foreground = fg_reg;
    assign absorbed   = abs_reg;
    assign new_bg0    = bg_reg[0];
    assign new_bg1    = bg_reg[1];
    assign new_bg2    = bg_reg[2];

endmodule

/* test/background_tracker_pkg.sv */
// scoreboard for the running-average background subtractor testbench
// holds the per-pixel background/counter predictor and the queue of expected verdicts
// depends on rabs_pkg
`timescale 1ns / 100ps

package background_tracker_pkg;

    import rabs_pkg::*;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIFF_THRESHOLD   = 3'd0,
        REG_BLEND_ALPHA      = 3'd1,
        REG_SELECTIVE_UPDATE = 3'd2,
        REG_ABSORB_LIMIT     = 3'd3,
        REG_COLOR_MODE       = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic             foreground;
        logic             absorbed;
        logic [PIX_W-1:0] new_bg0;
        logic [PIX_W-1:0] new_bg1;
        logic [PIX_W-1:0] new_bg2;
    } pixel_verdict_t;

    class background_tracker;

        cfg_t           cfg;
        int unsigned    mismatches;
        pixel_verdict_t expected_verdicts[$];

        // sparse copies of the block's per-pixel state
        logic [CHAN_COUNT-1:0][PIX_W-1:0] bg_word [int unsigned];
        logic [CNT_W-1:0]                 fg_count [int unsigned];

        function new();
            cfg.diff_threshold   = 8'd30;
            cfg.blend_alpha_q8   = 9'd13;
            cfg.selective_update = 1'b1;
            cfg.absorb_limit     = 8'd50;
            cfg.color_mode       = 1'b0;
            mismatches           = 0;
        endfunction

        function void set_register(reg_index_t r, logic [CFG_DATA_W-1:0] value);
            case (r)
                REG_DIFF_THRESHOLD:   cfg.diff_threshold   = value[PIX_W-1:0];
                REG_BLEND_ALPHA:      cfg.blend_alpha_q8   = value[ALPHA_W-1:0];
                REG_SELECTIVE_UPDATE: cfg.selective_update = value[0];
                REG_ABSORB_LIMIT:     cfg.absorb_limit     = value[CNT_W-1:0];
                REG_COLOR_MODE:       cfg.color_mode       = value[0];
                default: ;
            endcase
        endfunction

        function bit is_loaded(logic [PIX_IDX_W-1:0] idx);
            return bg_word.exists(idx);
        endfunction

        function logic [CHAN_COUNT-1:0][PIX_W-1:0] background_of(logic [PIX_IDX_W-1:0] idx);
            return bg_word[idx];
        endfunction

        function int unsigned pending();
            return expected_verdicts.size();
        endfunction

        // Q8 blend, rounding half up
        function logic [PIX_W-1:0] mix_toward(int unsigned p, int unsigned b, int unsigned a);
            int unsigned s;
            s = (p * a + b * (256 - a) + 128) >> 8;
            return s[PIX_W-1:0];
        endfunction

        // predict the verdict of one accepted input transfer
        function void note_pixel(logic act, logic [PIX_IDX_W-1:0] idx,
                                 logic [CHAN_COUNT-1:0][PIX_W-1:0] px);
            logic [CHAN_COUNT-1:0][PIX_W-1:0] bg;
            pixel_verdict_t v;
            int unsigned used, diff, a, cnt;
            logic is_fg;
            logic was_absorbed;

            v = '0;
            is_fg = 1'b0;
            was_absorbed = 1'b0;
            used = cfg.color_mode ? CHAN_COUNT : 1;
            if (idx >= PIXEL_COUNT) begin
                expected_verdicts.push_back(v);
                return;
            end
            if (act == ACT_LOAD) begin
                bg = px;
                bg_word[idx] = bg;
                fg_count[idx] = '0;
            end else begin
                bg = bg_word[idx];
                for (int c = 0; c < used; c++) begin
                    diff = (px[c] > bg[c]) ? px[c] - bg[c] : bg[c] - px[c];
                    if (diff > cfg.diff_threshold)
                        is_fg = 1'b1;
                end
                a = (cfg.blend_alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha_q8;
                if (!cfg.selective_update || !is_fg) begin
                    for (int c = 0; c < used; c++)
                        bg[c] = mix_toward(px[c], bg[c], a);
                end
                cnt = fg_count[idx] + is_fg;
                if (cnt > 255)
                    cnt = 255;
                if (cnt > cfg.absorb_limit) begin
                    was_absorbed = 1'b1;
                    for (int c = 0; c < used; c++)
                        bg[c] = px[c];
                end
                if (!is_fg)
                    cnt = 0;
                fg_count[idx] = cnt[CNT_W-1:0];
                bg_word[idx] = bg;
            end
            v.foreground = is_fg;
            v.absorbed   = was_absorbed;
            v.new_bg0    = bg[0];
            v.new_bg1    = cfg.color_mode ? bg[1] : '0;
            v.new_bg2    = cfg.color_mode ? bg[2] : '0;
            expected_verdicts.push_back(v);
        endfunction

        function void flag(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        endfunction

        // compare one output transfer with the oldest expectation
        function void check_verdict(pixel_verdict_t got);
            pixel_verdict_t want;
            if (expected_verdicts.size() == 0) begin
                $display("%0t ns: output transfer with nothing expected, fg %0d abs %0d bg %0d %0d %0d",
                         $time, got.foreground, got.absorbed, got.new_bg0, got.new_bg1, got.new_bg2);
                mismatches++;
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.foreground !== want.foreground)
                flag("foreground", want.foreground, got.foreground);
            if (got.absorbed !== want.absorbed)
                flag("absorbed", want.absorbed, got.absorbed);
            if (got.new_bg0 !== want.new_bg0)
                flag("new_bg0", want.new_bg0, got.new_bg0);
            if (got.new_bg1 !== want.new_bg1)
                flag("new_bg1", want.new_bg1, got.new_bg1);
            if (got.new_bg2 !== want.new_bg2)
                flag("new_bg2", want.new_bg2, got.new_bg2);
        endfunction

    endclass

endpackage

/* test/running_average_background_subtractor_core_tb.sv */
// testbench top for running_average_background_subtractor_core: drives pixel transfers,
// writes the configuration between phases and checks every result against the tracker
// depends on rabs_pkg, background_tracker_pkg and the block's RTL
`timescale 1ns / 100ps

module running_average_background_subtractor_core_tb;

    import rabs_pkg::*;
    import background_tracker_pkg::*;

    localparam int          POOL_SIZE     = 20;
    localparam int          SETTLE_CYCLES = 8;
    localparam longint      TIMEOUT_NS    = 4_000_000;
    // pixel that is kept foreground long enough to saturate its counter
    localparam logic [PIX_IDX_W-1:0] HELD_IDX = 19'h3_0F0F;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_CHOKED
    } sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [PIX_IDX_W-1:0]  pixel_index;
    logic [PIX_W-1:0]      chan0;
    logic [PIX_W-1:0]      chan1;
    logic [PIX_W-1:0]      chan2;
    logic                  out_valid;
    logic                  out_ready;
    logic                  foreground;
    logic                  absorbed;
    logic [PIX_W-1:0]      new_bg0;
    logic [PIX_W-1:0]      new_bg1;
    logic [PIX_W-1:0]      new_bg2;

    background_tracker tracker = new();

    // a handful of pixels revisited over and over so counters build up
    logic [PIX_IDX_W-1:0] pixel_pool [POOL_SIZE];

    running_average_background_subtractor_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pixel_index (pixel_index),
        .chan0       (chan0),
        .chan1       (chan1),
        .chan2       (chan2),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .foreground  (foreground),
        .absorbed    (absorbed),
        .new_bg0     (new_bg0),
        .new_bg1     (new_bg1),
        .new_bg2     (new_bg2)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case a transfer never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("running_average_background_subtractor_core_tb: FAIL");
        $finish;
    end

    // value close to the background: mostly inside the threshold, sometimes far or at the rails
    function automatic logic [PIX_W-1:0] nudge(logic [PIX_W-1:0] base);
        int v;
        case ($urandom_range(0, 3))
            0: v = int'(base) + int'($urandom_range(0, 16)) - 8;
            1: v = int'(base);
            2: v = int'($urandom_range(0, 255));
            default: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    // value on the opposite side of the range, at least 108 away
    function automatic logic [PIX_W-1:0] far_from(logic [PIX_W-1:0] base);
        return base[PIX_W-1] ? PIX_W'($urandom_range(0, 20)) : PIX_W'($urandom_range(235, 255));
    endfunction

    // one input transfer: hold valid and payload until the block takes it
    task automatic send_pixel(logic act, logic [PIX_IDX_W-1:0] idx,
                              logic [CHAN_COUNT-1:0][PIX_W-1:0] px);
        action      <= act;
        pixel_index <= idx;
        chan0       <= px[0];
        chan1       <= px[1];
        chan2       <= px[2];
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.note_pixel(act, idx, px);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t r, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.set_register(r, value);
    endtask

    // full register set, only ever called with the block idle
    task automatic apply_settings(logic [PIX_W-1:0] thr, logic [ALPHA_W-1:0] alpha,
                                  logic sel, logic [CNT_W-1:0] lim, logic color);
        write_reg(REG_DIFF_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_BLEND_ALPHA, CFG_DATA_W'(alpha));
        write_reg(REG_SELECTIVE_UPDATE, CFG_DATA_W'(sel));
        write_reg(REG_ABSORB_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_COLOR_MODE, CFG_DATA_W'(color));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // keep one pixel foreground for a run of transfers
    task automatic pin_pixel(logic [PIX_IDX_W-1:0] idx, int unsigned count);
        logic [CHAN_COUNT-1:0][PIX_W-1:0] bg;
        logic [CHAN_COUNT-1:0][PIX_W-1:0] px;
        repeat (count)
        begin
            bg = tracker.background_of(idx);
            for (int c = 0; c < CHAN_COUNT; c++)
                px[c] = far_from(bg[c]);
            send_pixel(ACT_PROCESS, idx, px);
        end
    endtask

    // random traffic in bursts; a quarter of the bursts hold one pixel in the foreground
    task automatic random_pixels(int unsigned count);
        int unsigned left;
        int unsigned burst;
        int unsigned gap;
        bit sticky;
        logic act;
        logic [PIX_IDX_W-1:0] idx;
        logic [PIX_IDX_W-1:0] anchor;
        logic [CHAN_COUNT-1:0][PIX_W-1:0] bg;
        logic [CHAN_COUNT-1:0][PIX_W-1:0] px;

        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            sticky = ($urandom_range(0, 3) == 0);
            anchor = pixel_pool[$urandom_range(0, POOL_SIZE - 1)];
            repeat (burst)
            begin
                if (sticky)
                    idx = anchor;
                else if ($urandom_range(0, 19) == 0)
                    idx = PIX_IDX_W'($urandom);    // stray pixel anywhere in the frame
                else
                    idx = pixel_pool[$urandom_range(0, POOL_SIZE - 1)];
                // a pixel is loaded before it is processed; stray reloads break runs
                if (!tracker.is_loaded(idx) || $urandom_range(0, 99) < 8)
                begin
                    act = ACT_LOAD;
                    px  = (CHAN_COUNT * PIX_W)'($urandom);
                end
                else
                begin
                    act = ACT_PROCESS;
                    bg  = tracker.background_of(idx);
                    for (int c = 0; c < CHAN_COUNT; c++)
                        px[c] = sticky ? far_from(bg[c]) : nudge(bg[c]);
                end
                send_pixel(act, idx, px);
            end
            left -= burst;
            // idle gap between bursts, often none so back-to-back transfers happen
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (left > 0 && gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // output side: check each result transfer, stall in changing patterns
    initial
    begin : result_sink
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned tick;

        out_ready <= 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_verdict(pixel_verdict_t'({foreground, absorbed,
                                                        new_bg0, new_bg1, new_bg2}));
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
                SINK_OPEN:     out_ready <= 1'b1;
                SINK_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
                SINK_PERIODIC: out_ready <= (tick % 5 != 0);
                default:       out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // stimulus: reset, directed pixels, then configuration phases with random traffic
    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        in_valid    <= 1'b0;
        action      <= ACT_LOAD;
        pixel_index <= '0;
        chan0       <= '0;
        chan1       <= '0;
        chan2       <= '0;

        pixel_pool[0] = '0;
        pixel_pool[1] = '1;
        pixel_pool[2] = 19'h2_AAAA;
        pixel_pool[3] = 19'h5_5555;
        for (int i = 4; i < POOL_SIZE; i++)
            pixel_pool[i] = PIX_IDX_W'($urandom);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed part under the reset settings: gray, threshold 30, alpha 13,
        // selective update, absorb limit 50
        send_pixel(ACT_LOAD, 19'h0_0000, {8'd0, 8'd0, 8'd0});
        send_pixel(ACT_LOAD, 19'h7_FFFF, {8'd255, 8'd255, 8'd255});
        send_pixel(ACT_LOAD, 19'h2_AAAA, {8'h0F, 8'hAA, 8'h55});
        send_pixel(ACT_LOAD, 19'h5_5555, {8'hF0, 8'h55, 8'hAA});
        // difference equal to the threshold stays background and blends
        send_pixel(ACT_PROCESS, 19'h0_0000, {8'd255, 8'd255, 8'd30});
        // one above the threshold: foreground, background kept
        send_pixel(ACT_PROCESS, 19'h0_0000, {8'd0, 8'd0, 8'd33});
        send_pixel(ACT_PROCESS, 19'h0_0000, {8'd0, 8'd0, 8'd2});
        send_pixel(ACT_PROCESS, 19'h7_FFFF, {8'd0, 8'd0, 8'd0});
        send_pixel(ACT_PROCESS, 19'h7_FFFF, {8'd0, 8'd0, 8'd255});
        // gray mode ignores channels 1 and 2 even when they are far off
        send_pixel(ACT_PROCESS, 19'h2_AAAA, {8'h00, 8'h00, 8'h55});
        send_pixel(ACT_PROCESS, 19'h5_5555, {8'hFF, 8'hFF, 8'hBF});
        // reload a pixel, then process the same pixel twice right behind the reload
        send_pixel(ACT_LOAD, 19'h0_0000, {8'd9, 8'd8, 8'd200});
        send_pixel(ACT_PROCESS, 19'h0_0000, {8'd9, 8'd8, 8'd0});
        send_pixel(ACT_PROCESS, 19'h0_0000, {8'd9, 8'd8, 8'd198});
        drain();

        // small threshold and limit in color mode so absorption happens often
        apply_settings(8'd20, 9'd64, 1'b1, 8'd3, 1'b1);
        random_pixels(14);
        drain();

        // zero threshold, alpha of one, blend everything, absorb on first foreground
        apply_settings(8'd0, 9'd256, 1'b0, 8'd0, 1'b1);
        random_pixels(14);
        drain();

        // top threshold never flags foreground; zero alpha never moves the background
        apply_settings(8'd255, 9'd0, 1'b1, 8'd255, 1'b1);
        random_pixels(14);
        drain();

        // alpha beyond one saturates; gray mode again
        apply_settings(8'd40, 9'd511, 1'b0, 8'd7, 1'b0);
        random_pixels(14);
        drain();

        // counter saturation: no absorption at limit 255 however long the object stays
        apply_settings(8'd20, 9'd128, 1'b1, 8'd255, 1'b1);
        send_pixel(ACT_LOAD, HELD_IDX, {8'h40, 8'hC0, 8'h80});
        pin_pixel(HELD_IDX, 258);
        random_pixels(14);
        drain();

        // a saturated counter is absorbed as soon as the limit drops below it
        apply_settings(8'd20, 9'd300, 1'b1, 8'd254, 1'b1);
        pin_pixel(HELD_IDX, 1);
        random_pixels(14);
        drain();

        apply_settings(8'd10, 9'd1, 1'b0, 8'd1, 1'b0);
        random_pixels(14);
        drain();

        // two phases with random settings
        repeat (2)
        begin
            apply_settings(PIX_W'($urandom_range(0, 255)), ALPHA_W'($urandom_range(0, 511)),
                           1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 15)),
                           1'($urandom_range(0, 1)));
            random_pixels(14);
            drain();
        end

        if (tracker.mismatches == 0)
            $display("running_average_background_subtractor_core_tb: PASS");
        else
            $display("running_average_background_subtractor_core_tb: FAIL");
        $finish;
    end

endmodule

/* running_average_background_subtractor_core.f */
src/rabs_pkg.sv
src/rabs_front.sv
src/rabs_back.sv
src/running_average_background_subtractor_core.sv
test/background_tracker_pkg.sv
test/running_average_background_subtractor_core_tb.sv
